### rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define ADLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define ADLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/adle_pkg.sv
package adle_pkg;

    localparam int RING_DEPTH_DEF = 1024;
    localparam int CENTER_DELAY   = 512;
    localparam int CHORUS_TAPS    = 4;
    localparam int SINE_DEPTH     = 256;
    localparam int SINE_AW        = 8;
    localparam int RING_AW_MAX    = 16;
    localparam int QW             = 26;
    localparam int CFG_DW         = 40;
    localparam int CFG_IW         = 3;

    localparam logic [CFG_IW-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_VSTEP   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_VDEPTH  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_CHORUS  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_EDELAY  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_TSTEP   = 3'd5;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef logic signed [15:0] sine_tab_t [SINE_DEPTH];

    typedef struct packed {
        logic                     we;
        logic [RING_AW_MAX-1:0]   waddr;
        logic signed [15:0]       wdata;
        logic                     re;
        logic [RING_AW_MAX-1:0]   raddr;
    } ring_req_t;

    // Quarter-wave fold and nested Taylor series in Q30, rounded to Q15.
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   tab;
        logic [63:0] q4, quad, r, x, x2, t, s, m;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            q4   = 64'(4 * k);
            quad = q4 / SINE_DEPTH;
            r    = q4 % SINE_DEPTH;
            if (quad[0])
                r = 64'(SINE_DEPTH) - r;
            x  = (HALF_PI_Q30 * r) / SINE_DEPTH;
            x2 = (x * x) >> 30;
            t  = ONE_Q30 - x2 / 72;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            m  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            if (m > 64'd32767)
                m = 64'd32767;
            tab[k] = (quad >= 64'd2) ? -$signed(16'(m)) : $signed(16'(m));
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        if (v > 40'sd32767)
            return 16'sh7fff;
        else if (v < -40'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // Linear blend of two neighbours, fraction in 1/256, ties rounded up.
    function automatic logic signed [15:0] interp(input logic signed [15:0] s0,
                                                  input logic signed [15:0] s1,
                                                  input logic [7:0] f);
        logic signed [26:0] v;
        logic signed [26:0] r;
        v = 27'(s0) * $signed({18'd0, 9'(9'd256 - {1'b0, f})})
            + 27'(s1) * $signed({19'd0, f});
        r = (v + 27'sd128) >>> 8;
        return sat16(40'(r));
    endfunction

endpackage

### rtl/adle_in_if.sv
interface adle_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

### rtl/adle_out_if.sv
interface adle_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

### rtl/adle_ring.sv
module adle_ring #(
    parameter int DEPTH = adle_pkg::RING_DEPTH_DEF
) (
    input  logic                clk,
    input  adle_pkg::ring_req_t req,
    output logic signed [15:0]  rdata
);

    localparam int AW = $clog2(DEPTH);

    logic signed [15:0] ring_reg [DEPTH];
    logic signed [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
            ring_reg[req.waddr[AW-1:0]] <= req.wdata;
        if (req.re)
            rdata_reg <= ring_reg[req.raddr[AW-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/audio_delay_line_effects_core.sv
// Delay-line effects core: vibrato, chorus, echo and tremolo on a Q1.15 stream.
// din carries one sample per request (valid/ready); dout returns one processed
// sample per input request, in order. cfg_we/cfg_index/cfg_data write the six
// control registers (mode, vibrato step, vibrato depth, chorus offsets, echo
// delay, tremolo step); write them only while no sample is in flight.
// One sample at a time: after acceptance the core makes eight reads of the
// delay memory through its one read port (two per interpolated tap, four
// chorus taps), then loads dout. A new sample can be taken in the cycle
// after dout is loaded.
// din.ready is high whenever the core is idle, also while dout still waits.
// If dout is stalled when the next result is ready, the core holds that
// result internally and accepts nothing until dout is taken.
// Reset empties the delay line at once: a fill count masks entries never
// written, which read as zero. Phases, write pointer and control registers clear.
module audio_delay_line_effects_core #(
    parameter int RING_DEPTH = adle_pkg::RING_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    adle_in_if.sink                       din,
    adle_out_if.source                    dout,
    input  logic                          cfg_we,
    input  logic [adle_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [adle_pkg::CFG_DW-1:0]   cfg_data
);

    localparam int QW = adle_pkg::QW;
    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(RING_DEPTH);
    localparam logic [AW-1:0] DMAX = AW'(RING_DEPTH - 1);
    localparam int CBASE_I = (adle_pkg::CENTER_DELAY > RING_DEPTH - 1) ?
                             RING_DEPTH - 1 : adle_pkg::CENTER_DELAY;
    localparam logic [AW-1:0] CBASE = AW'(CBASE_I);
    localparam logic signed [QW-1:0] QHI  = QW'((RING_DEPTH - 2) * 256 + 255);
    localparam logic signed [QW-1:0] QCEN = QW'(adle_pkg::CENTER_DELAY * 256);
    localparam logic signed [QW-1:0] ICEN = QW'(adle_pkg::CENTER_DELAY);
    localparam logic signed [QW-1:0] IMAX = QW'(RING_DEPTH - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_QCALC = 4'd2;
    localparam logic [3:0] ST_READ  = 4'd3;
    localparam logic [3:0] ST_DRAIN = 4'd4;
    localparam logic [3:0] ST_C1    = 4'd5;
    localparam logic [3:0] ST_C2    = 4'd6;
    localparam logic [3:0] ST_C3    = 4'd7;
    localparam logic [3:0] ST_C4    = 4'd8;
    localparam logic [3:0] ST_C5    = 4'd9;

    localparam logic [2:0] OP_V0 = 3'd0;
    localparam logic [2:0] OP_V1 = 3'd1;
    localparam logic [2:0] OP_C0 = 3'd2;
    localparam logic [2:0] OP_C1 = 3'd3;
    localparam logic [2:0] OP_C2 = 3'd4;
    localparam logic [2:0] OP_C3 = 3'd5;
    localparam logic [2:0] OP_E0 = 3'd6;
    localparam logic [2:0] OP_E1 = 3'd7;

    // control registers
    logic [3:0]  mode_reg;
    logic [31:0] vstep_reg;
    logic [16:0] vdepth_reg;
    logic [39:0] chorus_reg;
    logic [16:0] edelay_reg;
    logic [31:0] tstep_reg;
    logic [31:0] vphase_reg;
    logic [31:0] tphase_reg;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    opi_reg, opi_next;
    logic [2:0]    opd_reg;
    logic          cap_reg;
    logic          live_d_reg;
    logic [AW:0]   fill_reg;
    logic [AW-1:0] widx_reg;
    logic [AW-1:0] newest_reg;
    logic          ovalid_reg;
    logic          accept;
    logic          out_load;

    // datapath registers
    logic signed [15:0] vsin_reg, tsin_reg;
    logic signed [33:0] vprod_reg;
    logic [AW-1:0]      wv_reg, we_reg;
    logic [7:0]         fv_reg, fe_reg;
    logic [AW-1:0]      chd_reg [adle_pkg::CHORUS_TAPS];
    logic signed [15:0] tap_reg [8];
    logic signed [15:0] samp_reg, echo_reg;
    logic signed [17:0] csum_reg;
    logic signed [31:0] tprod_reg;
    logic signed [15:0] odata_reg;

    logic signed [15:0] rdata;
    adle_pkg::ring_req_t ring_req;

    logic [AW-1:0] rd_d;
    logic [AW:0]   rd_sum;
    logic [AW:0]   rd_addr;
    logic          rd_live;

    assign accept   = din.valid && din.ready;
    assign din.ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_C5) && (!ovalid_reg || dout.ready);
    assign dout.valid      = ovalid_reg;
    assign dout.sample_out = odata_reg;

    // configuration and phase accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            vstep_reg  <= '0;
            vdepth_reg <= '0;
            chorus_reg <= '0;
            edelay_reg <= '0;
            tstep_reg  <= '0;
            vphase_reg <= '0;
            tphase_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    adle_pkg::CFG_MODE:   mode_reg   <= cfg_data[3:0];
                    adle_pkg::CFG_VSTEP:  vstep_reg  <= cfg_data[31:0];
                    adle_pkg::CFG_VDEPTH: vdepth_reg <= cfg_data[16:0];
                    adle_pkg::CFG_CHORUS: chorus_reg <= cfg_data[39:0];
                    adle_pkg::CFG_EDELAY: edelay_reg <= cfg_data[16:0];
                    adle_pkg::CFG_TSTEP:  tstep_reg  <= cfg_data[31:0];
                    default: ;
                endcase
            end
            if (cfg_we && cfg_index == adle_pkg::CFG_VSTEP)
                vphase_reg <= '0;
            else if (accept && mode_reg[0])
                vphase_reg <= vphase_reg + vstep_reg;
            if (cfg_we && cfg_index == adle_pkg::CFG_TSTEP)
                tphase_reg <= '0;
            else if (accept && mode_reg[3])
                tphase_reg <= tphase_reg + tstep_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        opi_next   = opi_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_MUL;
            ST_MUL:   state_next = ST_QCALC;
            ST_QCALC:
            begin
                state_next = ST_READ;
                opi_next   = OP_V0;
            end
            ST_READ:
            begin
                opi_next = opi_reg + 3'd1;
                if (opi_reg == OP_E1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_C1;
            ST_C1:    state_next = ST_C2;
            ST_C2:    state_next = ST_C3;
            ST_C3:    state_next = ST_C4;
            ST_C4:    state_next = ST_C5;
            ST_C5:    if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            opi_reg    <= OP_V0;
            opd_reg    <= OP_V0;
            cap_reg    <= 1'b0;
            live_d_reg <= 1'b0;
            fill_reg   <= '0;
            widx_reg   <= '0;
            newest_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            opi_reg    <= opi_next;
            opd_reg    <= opi_reg;
            cap_reg    <= (state_reg == ST_READ);
            live_d_reg <= rd_live;
            if (accept)
            begin
                newest_reg <= widx_reg;
                widx_reg   <= (widx_reg == DMAX) ? '0 : widx_reg + 1'b1;
                if (fill_reg != DEPTH_W)
                    fill_reg <= fill_reg + 1'b1;
            end
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (dout.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // tap delay for the read being issued
    always_comb
    begin
        case (opi_reg)
            OP_V0:   rd_d = mode_reg[0] ? wv_reg : CBASE;
            OP_V1:   rd_d = wv_reg + 1'b1;
            OP_C0:   rd_d = chd_reg[0];
            OP_C1:   rd_d = chd_reg[1];
            OP_C2:   rd_d = chd_reg[2];
            OP_C3:   rd_d = chd_reg[3];
            OP_E0:   rd_d = we_reg;
            OP_E1:   rd_d = we_reg + 1'b1;
            default: rd_d = CBASE;
        endcase
        rd_live = ({1'b0, rd_d} < fill_reg);
        rd_sum  = {1'b0, newest_reg} + DEPTH_W - {1'b0, rd_d};
        rd_addr = (rd_sum >= DEPTH_W) ? rd_sum - DEPTH_W : rd_sum;
    end

    always_comb
    begin
        ring_req.we    = accept;
        ring_req.waddr = adle_pkg::RING_AW_MAX'(widx_reg);
        ring_req.wdata = din.sample_in;
        ring_req.re    = (state_reg == ST_READ);
        ring_req.raddr = adle_pkg::RING_AW_MAX'(rd_addr[AW-1:0]);
    end

    adle_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .req   (ring_req),
        .rdata (rdata)
    );

    logic signed [33:0]   off;
    logic signed [QW-1:0] qv, qe, qvc, qec;
    logic signed [QW-1:0] dc [adle_pkg::CHORUS_TAPS];
    logic signed [15:0]   vib_i, echo_i;
    logic signed [18:0]   ch_t, ch_q;
    logic signed [16:0]   ec_t, ec_q;
    logic signed [31:0]   tr_r;

    always_comb
    begin
        off = (vprod_reg + 34'sd16384) >>> 15;
        qv  = QCEN - QW'(off);
        qvc = (qv < 0) ? '0 : ((qv > QHI) ? QHI : qv);
        qe  = QCEN + QW'({1'b0, edelay_reg});
        qec = (qe > QHI) ? QHI : qe;
        for (int i = 0; i < adle_pkg::CHORUS_TAPS; i++)
        begin
            dc[i] = ICEN - QW'($signed(chorus_reg[10*i +: 10]));
            if (dc[i] < 0)
                dc[i] = '0;
            else if (dc[i] > IMAX)
                dc[i] = IMAX;
        end
        vib_i  = adle_pkg::interp(tap_reg[0], tap_reg[1], fv_reg);
        echo_i = adle_pkg::interp(tap_reg[6], tap_reg[7], fe_reg);
        // chorus and echo mixes truncate toward zero
        ch_t = 19'(samp_reg) + 19'(csum_reg);
        ch_q = (ch_t + (ch_t[18] ? 19'sd3 : 19'sd0)) >>> 2;
        ec_t = 17'(samp_reg) + 17'(echo_reg);
        ec_q = (ec_t + (ec_t[16] ? 17'sd1 : 17'sd0)) >>> 1;
        tr_r = (tprod_reg + 32'sd16384) >>> 15;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vsin_reg <= adle_pkg::SINE_TAB[vphase_reg[31 -: adle_pkg::SINE_AW]];
            tsin_reg <= adle_pkg::SINE_TAB[tphase_reg[31 -: adle_pkg::SINE_AW]];
        end
        if (state_reg == ST_MUL)
            vprod_reg <= $signed({1'b0, vdepth_reg}) * vsin_reg;
        if (state_reg == ST_QCALC)
        begin
            wv_reg <= qvc[AW+7:8];
            fv_reg <= qvc[7:0];
            we_reg <= qec[AW+7:8];
            fe_reg <= qec[7:0];
            for (int i = 0; i < adle_pkg::CHORUS_TAPS; i++)
                chd_reg[i] <= dc[i][AW-1:0];
        end
        if (cap_reg)
            tap_reg[opd_reg] <= live_d_reg ? rdata : 16'sd0;
        if (state_reg == ST_C1)
        begin
            samp_reg <= mode_reg[0] ? vib_i : tap_reg[0];
            echo_reg <= echo_i;
            csum_reg <= 18'(tap_reg[2]) + 18'(tap_reg[3]) + 18'(tap_reg[4]) + 18'(tap_reg[5]);
        end
        if (state_reg == ST_C2 && mode_reg[1])
            samp_reg <= adle_pkg::sat16(40'(ch_q));
        if (state_reg == ST_C3 && mode_reg[2])
            samp_reg <= ec_q[15:0];
        if (state_reg == ST_C4)
            tprod_reg <= samp_reg * tsin_reg;
        if (out_load)
            odata_reg <= mode_reg[3] ? adle_pkg::sat16(40'(tr_r)) : samp_reg;
    end

endmodule

### rtl/adle_checker.sv
`include "assert_macros.svh"

module adle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        din_valid,
    input logic        din_ready,
    input logic        dout_valid,
    input logic        dout_ready,
    input logic [15:0] dout_sample_out
);

    `ADLE_ASSERT_NXT(a_out_hold, clk, rst_n, dout_valid && !dout_ready, dout_valid, "result dropped while stalled")
    `ADLE_ASSERT_NXT(a_out_stable, clk, rst_n, dout_valid && !dout_ready, $stable(dout_sample_out), "result changed while stalled")
    `ADLE_ASSERT_NXT(a_one_at_a_time, clk, rst_n, din_valid && din_ready, !din_ready, "second request taken during processing")
    `ADLE_ASSERT_NXT(a_no_instant_result, clk, rst_n, din_valid && din_ready, !$rose(dout_valid), "result appeared one cycle after request")

endmodule

bind audio_delay_line_effects_core adle_checker u_adle_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .din_valid       (din.valid),
    .din_ready       (din.ready),
    .dout_valid      (dout.valid),
    .dout_ready      (dout.ready),
    .dout_sample_out (dout.sample_out)
);
